>>> design/mbb_fifo_pkg.sv
// ----------------------------------------------------------------------------
// mbb_fifo_pkg
// Shared widths, request codes and defaults for the mirror-bit byte FIFO.
// ----------------------------------------------------------------------------
package mbb_fifo_pkg;

    localparam int REQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;

    // Capacity after reset, before clamping to the store depth.
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_DEPTH      = 1024;
    localparam int DEF_MAX_BLOCK  = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUT           = 3'd0,
        REQ_FORCE_PUT     = 3'd1,
        REQ_GET           = 3'd2,
        REQ_PEEK          = 3'd3,
        REQ_ADVANCE       = 3'd4,
        REQ_FORCE_ADVANCE = 3'd5,
        REQ_CLEAR         = 3'd6
    } t_req;

endpackage

>>> design/mirror_bit_byte_ring_fifo_top.sv
// ----------------------------------------------------------------------------
// mirror_bit_byte_ring_fifo_top
// Byte FIFO in a circular store with a mirror bit beside each index.
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  -------------------------------
//  request   in         i_in_valid / o_in_stall    i_req_type, i_data_in, i_length
//  result    out        o_out_valid / i_out_stall  o_data_out, o_count,
//                                                  o_fill_level, o_last
//  config    in         i_cfg_we                   i_cfg_wdata (capacity in use)
//
// A request that yields one result writes it straight into the result register.
// A get or peek of n bytes streams one byte per cycle, while the output is not
// stalled, from the store's single read port, and the next request is taken
// once the read stage has drained. Reset is synchronous and empties the FIFO;
// the store itself is not cleared. Output stalls hold the result register and
// back-pressure the read stage and the request channel.
// ----------------------------------------------------------------------------
module mirror_bit_byte_ring_fifo_top #(
    parameter int STORE_DEPTH    = mbb_fifo_pkg::DEF_DEPTH,
    parameter int MAX_BLOCK_READ = mbb_fifo_pkg::DEF_MAX_BLOCK
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [mbb_fifo_pkg::LEN_W-1:0]    i_cfg_wdata,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [mbb_fifo_pkg::REQ_W-1:0]    i_req_type,
    input  logic [mbb_fifo_pkg::BYTE_W-1:0]   i_data_in,
    input  logic [mbb_fifo_pkg::LEN_W-1:0]    i_length,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [mbb_fifo_pkg::BYTE_W-1:0]   o_data_out,
    output logic [mbb_fifo_pkg::LEN_W-1:0]    o_count,
    output logic [mbb_fifo_pkg::LEN_W-1:0]    o_fill_level,
    output logic                              o_last
);
    import mbb_fifo_pkg::*;

    localparam int AW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW        = $clog2(STORE_DEPTH + 1);
    localparam int LW        = (CW > LEN_W) ? CW : LEN_W;
    localparam int NW        = $clog2(MAX_BLOCK_READ + 1);
    localparam int RESET_CAP = (DEF_CAPACITY > STORE_DEPTH) ? STORE_DEPTH : DEF_CAPACITY;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    // Advance an index by n (n never above the capacity), flipping its mirror bit
    // on a pass of the last byte in use. Result is {wrap, index}.
    function automatic logic [AW:0] move_on(logic [AW-1:0] ptr, logic wrap,
                                            logic [CW-1:0] n, logic [CW-1:0] cap);
        logic [CW:0] pos;
        logic        w;
        pos = (CW+1)'(ptr) + (CW+1)'(n);
        w   = wrap;
        if (pos >= (CW+1)'(cap)) begin
            pos = pos - (CW+1)'(cap);
            w   = ~w;
        end
        if (pos >= (CW+1)'(cap)) begin
            pos = '0;
        end
        return {w, AW'(pos)};
    endfunction

    logic [BYTE_W-1:0] store [STORE_DEPTH];

    t_state            r_state;
    logic [CW-1:0]     r_cap;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     r_wr_ptr;
    logic              r_rd_wrap;
    logic              r_wr_wrap;
    logic [CW-1:0]     r_fill;
    logic [AW-1:0]     r_walk;
    logic [NW-1:0]     r_left;
    logic [LEN_W-1:0]  r_req_count;
    logic [LEN_W-1:0]  r_req_fill;
    logic              r_mem_valid;
    logic              r_mem_last;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic [LEN_W-1:0]  r_out_count;
    logic [LEN_W-1:0]  r_out_fill;
    logic              r_out_last;

    logic              out_free;
    logic              mem_to_out;
    logic              issue;
    logic              accept;
    t_req              req;

    logic [CW-1:0]     space;
    logic [LW-1:0]     len_lw;
    logic [LW-1:0]     lim_lw;
    logic [LW-1:0]     rd_n_lw;
    logic [CW-1:0]     rd_n;
    logic [CW-1:0]     adv_n;
    logic [CW-1:0]     fadv_n;
    logic [CW-1:0]     w_step;
    logic [AW:0]       w_mv;
    logic [AW:0]       r_mv;

    logic              wr_en;
    logic              start_read;
    logic [AW-1:0]     n_rd_ptr;
    logic              n_rd_wrap;
    logic [AW-1:0]     n_wr_ptr;
    logic              n_wr_wrap;
    logic [CW-1:0]     n_fill;
    logic [LW-1:0]     res_cnt;
    logic [LW-1:0]     fill_lw;

    logic [LW-1:0]     cfg_lw;
    logic [CW-1:0]     n_cap;
    logic [CW-1:0]     walk_inc;
    logic [AW-1:0]     n_walk;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign mem_to_out = r_mem_valid && out_free;
    assign issue      = (r_state == S_READ) && (!r_mem_valid || mem_to_out);
    assign o_in_stall = !((r_state == S_IDLE) && !r_mem_valid && out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign req        = t_req'(i_req_type);

    assign space   = r_cap - r_fill;
    assign len_lw  = LW'(i_length);
    assign lim_lw  = (len_lw > LW'(MAX_BLOCK_READ)) ? LW'(MAX_BLOCK_READ) : len_lw;
    assign rd_n_lw = (lim_lw > LW'(r_fill)) ? LW'(r_fill) : lim_lw;
    assign rd_n    = CW'(rd_n_lw);
    assign adv_n   = (len_lw > LW'(space)) ? space : CW'(i_length);
    assign fadv_n  = (len_lw > LW'(r_cap)) ? r_cap : CW'(i_length);

    always_comb begin
        if (req == REQ_ADVANCE) begin
            w_step = adv_n;
        end else if (req == REQ_FORCE_ADVANCE) begin
            w_step = fadv_n;
        end else begin
            w_step = CW'(1);
        end
    end

    assign w_mv = move_on(r_wr_ptr, r_wr_wrap, w_step, r_cap);
    assign r_mv = move_on(r_rd_ptr, r_rd_wrap, rd_n, r_cap);

    // Effect of one accepted request on the indices and the fill count.
    always_comb begin
        wr_en      = 1'b0;
        start_read = 1'b0;
        n_rd_ptr   = r_rd_ptr;
        n_rd_wrap  = r_rd_wrap;
        n_wr_ptr   = r_wr_ptr;
        n_wr_wrap  = r_wr_wrap;
        n_fill     = r_fill;
        res_cnt    = '0;
        case (req)
            REQ_PUT: begin
                if (space != '0) begin
                    wr_en                 = 1'b1;
                    {n_wr_wrap, n_wr_ptr} = w_mv;
                    n_fill                = r_fill + CW'(1);
                    res_cnt               = LW'(1);
                end
            end
            REQ_FORCE_PUT: begin
                wr_en                 = 1'b1;
                {n_wr_wrap, n_wr_ptr} = w_mv;
                res_cnt               = LW'(1);
                if (space == '0) begin
                    // Overrun: the oldest byte is gone and the FIFO stays full.
                    n_rd_ptr  = w_mv[AW-1:0];
                    n_rd_wrap = ~w_mv[AW];
                    n_fill    = r_cap;
                end else begin
                    n_fill = r_fill + CW'(1);
                end
            end
            REQ_GET: begin
                res_cnt = rd_n_lw;
                if (rd_n != '0) begin
                    start_read            = 1'b1;
                    {n_rd_wrap, n_rd_ptr} = r_mv;
                    n_fill                = r_fill - rd_n;
                end
            end
            REQ_PEEK: begin
                res_cnt    = rd_n_lw;
                start_read = (rd_n != '0);
            end
            REQ_ADVANCE: begin
                res_cnt               = LW'(adv_n);
                {n_wr_wrap, n_wr_ptr} = w_mv;
                n_fill                = r_fill + adv_n;
            end
            REQ_FORCE_ADVANCE: begin
                res_cnt               = LW'(fadv_n);
                {n_wr_wrap, n_wr_ptr} = w_mv;
                if (fadv_n > space) begin
                    n_rd_ptr  = w_mv[AW-1:0];
                    n_rd_wrap = ~w_mv[AW];
                    n_fill    = r_cap;
                end else begin
                    n_fill = r_fill + fadv_n;
                end
            end
            REQ_CLEAR: begin
                n_rd_ptr  = '0;
                n_rd_wrap = 1'b0;
                n_wr_ptr  = '0;
                n_wr_wrap = 1'b0;
                n_fill    = '0;
            end
            default: begin
            end
        endcase
    end

    assign fill_lw = LW'(n_fill);

    // Capacity write: round down to a multiple of four, then clamp.
    always_comb begin
        cfg_lw = LW'({i_cfg_wdata[LEN_W-1:2], 2'b00});
        if (cfg_lw < LW'(4)) begin
            cfg_lw = LW'(4);
        end
        if (cfg_lw > LW'(STORE_DEPTH)) begin
            cfg_lw = LW'(STORE_DEPTH);
        end
        n_cap = CW'(cfg_lw);
    end

    assign walk_inc = CW'(r_walk) + CW'(1);
    assign n_walk   = (walk_inc == r_cap) ? '0 : AW'(walk_inc);

    // Byte store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            store[r_wr_ptr] <= i_data_in;
        end
        if (issue) begin
            r_rdata <= store[r_walk];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept && start_read) begin
            r_walk      <= r_rd_ptr;
            r_req_count <= res_cnt[LEN_W-1:0];
            r_req_fill  <= fill_lw[LEN_W-1:0];
        end else if (issue) begin
            r_walk <= n_walk;
        end
        if (issue) begin
            r_mem_last <= (r_left == NW'(1));
        end
        if (accept && !start_read) begin
            r_out_data  <= '0;
            r_out_count <= res_cnt[LEN_W-1:0];
            r_out_fill  <= fill_lw[LEN_W-1:0];
            r_out_last  <= 1'b1;
        end else if (mem_to_out) begin
            r_out_data  <= r_rdata;
            r_out_count <= r_req_count;
            r_out_fill  <= r_req_fill;
            r_out_last  <= r_mem_last;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CW'(RESET_CAP);
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_rd_wrap   <= 1'b0;
            r_wr_wrap   <= 1'b0;
            r_fill      <= '0;
            r_left      <= '0;
            r_mem_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap     <= n_cap;
                r_rd_ptr  <= '0;
                r_wr_ptr  <= '0;
                r_rd_wrap <= 1'b0;
                r_wr_wrap <= 1'b0;
                r_fill    <= '0;
            end else if (accept) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_rd_wrap <= n_rd_wrap;
                r_wr_wrap <= n_wr_wrap;
                r_fill    <= n_fill;
            end

            if (accept && start_read) begin
                r_state <= S_READ;
                r_left  <= NW'(rd_n_lw);
            end else if (issue) begin
                r_left <= r_left - NW'(1);
                if (r_left == NW'(1)) begin
                    r_state <= S_IDLE;
                end
            end

            if (issue) begin
                r_mem_valid <= 1'b1;
            end else if (mem_to_out) begin
                r_mem_valid <= 1'b0;
            end

            if ((accept && !start_read) || mem_to_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_out   = r_out_data;
    assign o_count      = r_out_count;
    assign o_fill_level = r_out_fill;
    assign o_last       = r_out_last;

endmodule

>>> tb/mirror_bit_byte_ring_fifo_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mirror_bit_byte_ring_fifo_top_tb
// Self-checking bench for the mirror-bit byte FIFO. A shadow copy of the
// FIFO, kept beside the design, works out every result from each accepted
// request. A checker compares each result transfer with the oldest reply
// owed. Directed tasks cover the empty, full and overrun cases and the write
// advances. A back-pressure task and randomised phases at several
// capacities follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module mirror_bit_byte_ring_fifo_top_tb;
    import mbb_fifo_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  count;
        logic [LEN_W-1:0]  fill;
        logic              last;
    } t_fifo_reply;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic [REQ_W-1:0]  i_req_type  = '0;
    logic [BYTE_W-1:0] i_data_in   = '0;
    logic [LEN_W-1:0]  i_length    = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_data_out;
    logic [LEN_W-1:0]  o_count;
    logic [LEN_W-1:0]  o_fill_level;
    logic              o_last;

    // Shadow copy of the FIFO.
    logic [BYTE_W-1:0] shadow_store   [DEF_DEPTH];
    bit                shadow_written [DEF_DEPTH];
    int unsigned       shadow_rd;
    int unsigned       shadow_wr;
    bit                shadow_rd_wrap;
    bit                shadow_wr_wrap;
    int unsigned       shadow_cap;

    t_fifo_reply fifo_replies [$];
    t_fifo_reply head_reply;

    int  errors        = 0;
    int  items_sent    = 0;
    int  replies_seen  = 0;
    int  cfg_writes    = 0;
    int  cycle_count   = 0;
    bit  tx_idle       = 1'b1;
    bit  rx_idle       = 1'b1;
    int  hold_cycles   = 0;
    int  hold_requests = 0;
    int  holds_taken   = 0;
    int  rx_wait       = 0;

    mirror_bit_byte_ring_fifo_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_data_in    (i_data_in),
        .i_length     (i_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_out   (o_data_out),
        .o_count      (o_count),
        .o_fill_level (o_fill_level),
        .o_last       (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d replies owed.",
                     cycle_count, fifo_replies.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shadow FIFO
    // ------------------------------------------------------------------
    function automatic int unsigned clamp_capacity(input logic [LEN_W-1:0] raw);
        int unsigned c;
        c = int'(raw & ~11'd3);
        if (c < 4) c = 4;
        if (c > DEF_DEPTH) c = DEF_DEPTH;
        return c;
    endfunction

    function automatic void empty_shadow();
        shadow_rd      = 0;
        shadow_wr      = 0;
        shadow_rd_wrap = 1'b0;
        shadow_wr_wrap = 1'b0;
    endfunction

    function automatic int unsigned shadow_fill();
        if (shadow_rd == shadow_wr) begin
            return (shadow_rd_wrap == shadow_wr_wrap) ? 0 : shadow_cap;
        end
        if (shadow_wr > shadow_rd) return shadow_wr - shadow_rd;
        return shadow_cap - (shadow_rd - shadow_wr);
    endfunction

    // A pointer that passes the last byte in use returns to zero and flips its wrap bit.
    function automatic void step_ptr(input int unsigned pos, input bit wrap,
                                     input int unsigned n, output int unsigned new_pos,
                                     output bit new_wrap);
        new_pos  = pos + n;
        new_wrap = wrap;
        if (new_pos >= shadow_cap) begin
            new_pos  = new_pos - shadow_cap;
            new_wrap = ~wrap;
        end
        if (new_pos >= shadow_cap) new_pos = 0;
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] data);
        shadow_store[shadow_wr]   = data;
        shadow_written[shadow_wr] = 1'b1;
        step_ptr(shadow_wr, shadow_wr_wrap, 1, shadow_wr, shadow_wr_wrap);
    endfunction

    // Overrunning the free space leaves the FIFO full at the write pointer.
    function automatic void overrun_to_full();
        shadow_rd      = shadow_wr;
        shadow_rd_wrap = ~shadow_wr_wrap;
    endfunction

    function automatic void serve_request(input logic [REQ_W-1:0] req,
                                          input logic [BYTE_W-1:0] data,
                                          input logic [LEN_W-1:0] len);
        int unsigned       held;
        int unsigned       space;
        int unsigned       n;
        int unsigned       k;
        int unsigned       pos;
        bit                wrap;
        logic [BYTE_W-1:0] taken [DEF_MAX_BLOCK];
        t_fifo_reply       r;
        held  = shadow_fill();
        space = shadow_cap - held;
        n     = 0;
        case (req)
            REQ_PUT: begin
                if (space != 0) begin
                    store_byte(data);
                    n = 1;
                end
            end
            REQ_FORCE_PUT: begin
                store_byte(data);
                if (space == 0) overrun_to_full();
                n = 1;
            end
            REQ_GET, REQ_PEEK: begin
                n = (int'(len) > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(len);
                if (n > held) n = held;
                if (n != 0) begin
                    pos  = shadow_rd;
                    wrap = shadow_rd_wrap;
                    for (k = 0; k < n; k++) begin
                        taken[k] = shadow_store[pos];
                        step_ptr(pos, wrap, 1, pos, wrap);
                    end
                    if (req == REQ_GET) begin
                        shadow_rd      = pos;
                        shadow_rd_wrap = wrap;
                    end
                    for (k = 0; k < n; k++) begin
                        r.data  = taken[k];
                        r.count = LEN_W'(n);
                        r.fill  = LEN_W'(shadow_fill());
                        r.last  = (k + 1 == n);
                        fifo_replies.push_back(r);
                    end
                    return;
                end
            end
            REQ_ADVANCE: begin
                n = (int'(len) > space) ? space : int'(len);
                if (n != 0) step_ptr(shadow_wr, shadow_wr_wrap, n, shadow_wr, shadow_wr_wrap);
            end
            REQ_FORCE_ADVANCE: begin
                n = (int'(len) > shadow_cap) ? shadow_cap : int'(len);
                step_ptr(shadow_wr, shadow_wr_wrap, n, shadow_wr, shadow_wr_wrap);
                if (n > space) overrun_to_full();
            end
            REQ_CLEAR: empty_shadow();
            default: ;
        endcase
        r.data  = '0;
        r.count = LEN_W'(n);
        r.fill  = LEN_W'(shadow_fill());
        r.last  = 1'b1;
        fifo_replies.push_back(r);
    endfunction

    // A read must never reach a store entry that has not been written yet, so
    // the length is cut at the first such entry.
    function automatic logic [LEN_W-1:0] safe_read_len(input logic [LEN_W-1:0] len);
        int unsigned want;
        int unsigned p;
        int unsigned k;
        want = (int'(len) > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : int'(len);
        if (want > shadow_fill()) want = shadow_fill();
        p = shadow_rd;
        for (k = 0; k < want; k++) begin
            if (!shadow_written[p]) break;
            p = (p + 1 >= shadow_cap) ? 0 : p + 1;
        end
        return (k < want) ? LEN_W'(k) : len;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 100) $display("Mismatch at result %0d: %s", replies_seen, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (hold_requests != holds_taken) begin
                holds_taken = hold_requests;
                rx_wait     = hold_cycles;
            end else if (o_out_valid === 1'b1 && !i_out_stall) begin
                rx_wait = rx_idle ? int'($urandom_range(0, 13)) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_stall <= (rx_wait > 0);
        end
    end

    always @(posedge i_clk) begin : reply_check
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            replies_seen++;
            if (fifo_replies.size() == 0) begin
                report_mismatch("result transfer with no reply owed");
            end else begin
                head_reply = fifo_replies.pop_front();
                if (o_data_out !== head_reply.data)
                    report_mismatch($sformatf("data_out %0h, wanted %0h",
                                              o_data_out, head_reply.data));
                if (o_count !== head_reply.count)
                    report_mismatch($sformatf("count %0d, wanted %0d",
                                              o_count, head_reply.count));
                if (o_fill_level !== head_reply.fill)
                    report_mismatch($sformatf("fill_level %0d, wanted %0d",
                                              o_fill_level, head_reply.fill));
                if (o_last !== head_reply.last)
                    report_mismatch($sformatf("last %0b, wanted %0b",
                                              o_last, head_reply.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic offer_request(input logic [REQ_W-1:0] req,
                                 input logic [BYTE_W-1:0] data,
                                 input logic [LEN_W-1:0] len);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 13)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_req_type <= REQ_W'($urandom_range(0, 7));
            i_data_in  <= BYTE_W'($urandom_range(0, 255));
            i_length   <= LEN_W'($urandom_range(0, 2047));
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_data_in  <= data;
        i_length   <= len;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        serve_request(req, data, len);
        items_sent++;
    endtask

    // Stops offering and waits until every owed reply has been transferred.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (fifo_replies.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [LEN_W-1:0] value);
        drain_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_cap = clamp_capacity(value);
        empty_shadow();
        cfg_writes++;
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_W'($urandom_range(0, 2047));
            2:       return LEN_W'(DEF_MAX_BLOCK + int'($urandom_range(0, 1)));
            3:       return LEN_W'(shadow_cap);
            default: return LEN_W'($urandom_range(1, 24));
        endcase
    endfunction

    task automatic random_request();
        int unsigned       pick;
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        pick = $urandom_range(0, 99);
        data = BYTE_W'($urandom_range(0, 255));
        len  = pick_length();
        if (pick < 40)      req = REQ_PUT;
        else if (pick < 50) req = REQ_FORCE_PUT;
        else if (pick < 68) req = REQ_GET;
        else if (pick < 78) req = REQ_PEEK;
        else if (pick < 86) req = REQ_ADVANCE;
        else if (pick < 91) req = REQ_FORCE_ADVANCE;
        else if (pick < 96) req = REQ_CLEAR;
        else                req = REQ_UNUSED;
        if (req == REQ_GET || req == REQ_PEEK) begin
            len = safe_read_len(len);
            // A hole left by a write advance blocks reads until it is cleared.
            if (shadow_fill() != 0 && !shadow_written[shadow_rd] && $urandom_range(0, 1))
                req = REQ_CLEAR;
        end
        offer_request(req, data, len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_empty_and_basic();
        offer_request(REQ_GET, 8'h00, 11'd0);
        offer_request(REQ_PEEK, 8'h5A, 11'd5);
        offer_request(REQ_PUT, 8'h00, 11'd0);
        offer_request(REQ_PUT, 8'hFF, 11'h7FF);
        offer_request(REQ_PUT, 8'hA5, 11'd3);
        offer_request(REQ_PEEK, 8'h00, 11'd2);
        offer_request(REQ_GET, 8'h00, 11'h7FF);
        offer_request(REQ_UNUSED, 8'hFF, 11'h7FF);
        offer_request(REQ_PUT, 8'h3C, 11'd0);
        offer_request(REQ_CLEAR, 8'h00, 11'd0);
    endtask

    task automatic test_full_and_overwrite();
        write_capacity(11'd3);
        offer_request(REQ_PUT, 8'h11, 11'd0);
        offer_request(REQ_PUT, 8'h22, 11'd0);
        offer_request(REQ_PUT, 8'h33, 11'd0);
        offer_request(REQ_PUT, 8'h44, 11'd0);
        offer_request(REQ_PUT, 8'h55, 11'd0);
        offer_request(REQ_FORCE_PUT, 8'h66, 11'd0);
        offer_request(REQ_GET, 8'h00, 11'd64);
    endtask

    task automatic test_write_advance();
        offer_request(REQ_ADVANCE, 8'h00, 11'd2);
        offer_request(REQ_ADVANCE, 8'h00, 11'd1024);
        offer_request(REQ_FORCE_ADVANCE, 8'h00, 11'd1);
        offer_request(REQ_FORCE_ADVANCE, 8'h00, 11'h7FF);
        offer_request(REQ_GET, 8'h00, 11'd64);
    endtask

    task automatic test_backpressure();
        int i;
        write_capacity(11'd32);
        tx_idle = 1'b0;
        hold_cycles = 150;
        hold_requests++;
        for (i = 0; i < 20; i++)
            offer_request(REQ_PUT, BYTE_W'($urandom_range(0, 255)), 11'd0);
        offer_request(REQ_GET, 8'h00, 11'd64);
        drain_replies();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        int caps [6] = '{16, 2047, 64, 7, 200, 1025};
        int burst;
        int i;
        foreach (caps[ph]) begin
            write_capacity(LEN_W'(caps[ph]));
            tx_idle = 1'($urandom_range(0, 1));
            rx_idle = 1'($urandom_range(0, 1));
            // A run of puts first, so that the reads later find data to stream.
            burst = (ph == 2 || ph == 4) ? 70 : ((shadow_cap < 12) ? shadow_cap : 12);
            for (i = 0; i < burst; i++)
                offer_request(REQ_PUT, BYTE_W'($urandom_range(0, 255)),
                              LEN_W'($urandom_range(0, 2047)));
            drain_replies();
            for (i = 0; i < 15; i++) begin
                if (i % 8 == 0) begin
                    tx_idle = 1'($urandom_range(0, 1));
                    rx_idle = 1'($urandom_range(0, 1));
                end
                random_request();
            end
        end
    endtask

    initial begin
        shadow_cap = clamp_capacity(LEN_W'(DEF_CAPACITY));
        empty_shadow();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_basic();
        test_full_and_overwrite();
        test_write_advance();
        test_backpressure();
        test_random_phases();
        drain_replies();
        repeat (80) @(posedge i_clk);
        if (fifo_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", fifo_replies.size()));
        $display("Covered %0d requests and %0d result transfers over %0d capacity writes,",
                 items_sent, replies_seen, cfg_writes);
        $display("including full, overrun, write advance and receiver hold-off cases.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
